@@ hdl/hpe_pkg.sv @@
`default_nettype none
package hpe_pkg;

   localparam int CODE_W  = 30;
   localparam int LEN_W   = 5;
   localparam int ACC_W   = CODE_W + 7;
   localparam int CNT_W   = 6;
   localparam int Q_DEPTH = 2;

   typedef struct packed {
      logic [7:0] symbol;
      logic       last_symbol;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_type;

   // code left-aligned in CODE_W bits
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
      logic              last;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   localparam logic [CODE_W-1:0] CODE_ROM [0:255] = '{
      30'h1ff8, 30'h7fffd8, 30'hfffffe2, 30'hfffffe3, 30'hfffffe4, 30'hfffffe5,
      30'hfffffe6, 30'hfffffe7,
      30'hfffffe8, 30'hffffea, 30'h3ffffffc, 30'hfffffe9, 30'hfffffea, 30'h3ffffffd,
      30'hfffffeb, 30'hfffffec,
      30'hfffffed, 30'hfffffee, 30'hfffffef, 30'hffffff0, 30'hffffff1, 30'hffffff2,
      30'h3ffffffe, 30'hffffff3,
      30'hffffff4, 30'hffffff5, 30'hffffff6, 30'hffffff7, 30'hffffff8, 30'hffffff9,
      30'hffffffa, 30'hffffffb,
      30'h14, 30'h3f8, 30'h3f9, 30'hffa, 30'h1ff9, 30'h15, 30'hf8, 30'h7fa,
      30'h3fa, 30'h3fb, 30'hf9, 30'h7fb, 30'hfa, 30'h16, 30'h17, 30'h18,
      30'h0, 30'h1, 30'h2, 30'h19, 30'h1a, 30'h1b, 30'h1c, 30'h1d,
      30'h1e, 30'h1f, 30'h5c, 30'hfb, 30'h7ffc, 30'h20, 30'hffb, 30'h3fc,
      30'h1ffa, 30'h21, 30'h5d, 30'h5e, 30'h5f, 30'h60, 30'h61, 30'h62,
      30'h63, 30'h64, 30'h65, 30'h66, 30'h67, 30'h68, 30'h69, 30'h6a,
      30'h6b, 30'h6c, 30'h6d, 30'h6e, 30'h6f, 30'h70, 30'h71, 30'h72,
      30'hfc, 30'h73, 30'hfd, 30'h1ffb, 30'h7fff0, 30'h1ffc, 30'h3ffc, 30'h22,
      30'h7ffd, 30'h3, 30'h23, 30'h4, 30'h24, 30'h5, 30'h25, 30'h26,
      30'h27, 30'h6, 30'h74, 30'h75, 30'h28, 30'h29, 30'h2a, 30'h7,
      30'h2b, 30'h76, 30'h2c, 30'h8, 30'h9, 30'h2d, 30'h77, 30'h78,
      30'h79, 30'h7a, 30'h7b, 30'h7ffe, 30'h7fc, 30'h3ffd, 30'h1ffd, 30'hffffffc,
      30'hfffe6, 30'h3fffd2, 30'hfffe7, 30'hfffe8, 30'h3fffd3, 30'h3fffd4, 30'h3fffd5,
      30'h7fffd9,
      30'h3fffd6, 30'h7fffda, 30'h7fffdb, 30'h7fffdc, 30'h7fffdd, 30'h7fffde, 30'hffffeb,
      30'h7fffdf,
      30'hffffec, 30'hffffed, 30'h3fffd7, 30'h7fffe0, 30'hffffee, 30'h7fffe1, 30'h7fffe2,
      30'h7fffe3,
      30'h7fffe4, 30'h1fffdc, 30'h3fffd8, 30'h7fffe5, 30'h3fffd9, 30'h7fffe6, 30'h7fffe7,
      30'hffffef,
      30'h3fffda, 30'h1fffdd, 30'hfffe9, 30'h3fffdb, 30'h3fffdc, 30'h7fffe8, 30'h7fffe9,
      30'h1fffde,
      30'h7fffea, 30'h3fffdd, 30'h3fffde, 30'hfffff0, 30'h1fffdf, 30'h3fffdf, 30'h7fffeb,
      30'h7fffec,
      30'h1fffe0, 30'h1fffe1, 30'h3fffe0, 30'h1fffe2, 30'h7fffed, 30'h3fffe1, 30'h7fffee,
      30'h7fffef,
      30'hfffea, 30'h3fffe2, 30'h3fffe3, 30'h3fffe4, 30'h7ffff0, 30'h3fffe5, 30'h3fffe6,
      30'h7ffff1,
      30'h3ffffe0, 30'h3ffffe1, 30'hfffeb, 30'h7fff1, 30'h3fffe7, 30'h7ffff2, 30'h3fffe8,
      30'h1ffffec,
      30'h3ffffe2, 30'h3ffffe3, 30'h3ffffe4, 30'h7ffffde, 30'h7ffffdf, 30'h3ffffe5,
      30'hfffff1, 30'h1ffffed,
      30'h7fff2, 30'h1fffe3, 30'h3ffffe6, 30'h7ffffe0, 30'h7ffffe1, 30'h3ffffe7,
      30'h7ffffe2, 30'hfffff2,
      30'h1fffe4, 30'h1fffe5, 30'h3ffffe8, 30'h3ffffe9, 30'hffffffd, 30'h7ffffe3,
      30'h7ffffe4, 30'h7ffffe5,
      30'hfffec, 30'hfffff3, 30'hfffed, 30'h1fffe6, 30'h3fffe9, 30'h1fffe7, 30'h1fffe8,
      30'h7ffff3,
      30'h3fffea, 30'h3fffeb, 30'h1ffffee, 30'h1ffffef, 30'hfffff4, 30'hfffff5,
      30'h3ffffea, 30'h7ffff4,
      30'h3ffffeb, 30'h7ffffe6, 30'h3ffffec, 30'h3ffffed, 30'h7ffffe7, 30'h7ffffe8,
      30'h7ffffe9, 30'h7ffffea,
      30'h7ffffeb, 30'hffffffe, 30'h7ffffec, 30'h7ffffed, 30'h7ffffee, 30'h7ffffef,
      30'h7fffff0, 30'h3ffffee
   };

   localparam logic [LEN_W-1:0] LEN_ROM [0:255] = '{
      5'd13, 5'd23, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
      5'd28, 5'd24, 5'd30, 5'd28, 5'd28, 5'd30, 5'd28, 5'd28,
      5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd30, 5'd28,
      5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
      5'd6, 5'd10, 5'd10, 5'd12, 5'd13, 5'd6, 5'd8, 5'd11,
      5'd10, 5'd10, 5'd8, 5'd11, 5'd8, 5'd6, 5'd6, 5'd6,
      5'd5, 5'd5, 5'd5, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6,
      5'd6, 5'd6, 5'd7, 5'd8, 5'd15, 5'd6, 5'd12, 5'd10,
      5'd13, 5'd6, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
      5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
      5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
      5'd8, 5'd7, 5'd8, 5'd13, 5'd19, 5'd13, 5'd14, 5'd6,
      5'd15, 5'd5, 5'd6, 5'd5, 5'd6, 5'd5, 5'd6, 5'd6,
      5'd6, 5'd5, 5'd7, 5'd7, 5'd6, 5'd6, 5'd6, 5'd5,
      5'd6, 5'd7, 5'd6, 5'd5, 5'd5, 5'd6, 5'd7, 5'd7,
      5'd7, 5'd7, 5'd7, 5'd15, 5'd11, 5'd14, 5'd13, 5'd28,
      5'd20, 5'd22, 5'd20, 5'd20, 5'd22, 5'd22, 5'd22, 5'd23,
      5'd22, 5'd23, 5'd23, 5'd23, 5'd23, 5'd23, 5'd24, 5'd23,
      5'd24, 5'd24, 5'd22, 5'd23, 5'd24, 5'd23, 5'd23, 5'd23,
      5'd23, 5'd21, 5'd22, 5'd23, 5'd22, 5'd23, 5'd23, 5'd24,
      5'd22, 5'd21, 5'd20, 5'd22, 5'd22, 5'd23, 5'd23, 5'd21,
      5'd23, 5'd22, 5'd22, 5'd24, 5'd21, 5'd22, 5'd23, 5'd23,
      5'd21, 5'd21, 5'd22, 5'd21, 5'd23, 5'd22, 5'd23, 5'd23,
      5'd20, 5'd22, 5'd22, 5'd22, 5'd23, 5'd22, 5'd22, 5'd23,
      5'd26, 5'd26, 5'd20, 5'd19, 5'd22, 5'd23, 5'd22, 5'd25,
      5'd26, 5'd26, 5'd26, 5'd27, 5'd27, 5'd26, 5'd24, 5'd25,
      5'd19, 5'd21, 5'd26, 5'd27, 5'd27, 5'd26, 5'd27, 5'd24,
      5'd21, 5'd21, 5'd26, 5'd26, 5'd28, 5'd27, 5'd27, 5'd27,
      5'd20, 5'd24, 5'd20, 5'd21, 5'd22, 5'd21, 5'd21, 5'd23,
      5'd22, 5'd22, 5'd25, 5'd25, 5'd24, 5'd24, 5'd26, 5'd23,
      5'd26, 5'd27, 5'd26, 5'd26, 5'd27, 5'd27, 5'd27, 5'd27,
      5'd27, 5'd28, 5'd27, 5'd27, 5'd27, 5'd27, 5'd27, 5'd26
   };

endpackage
`default_nettype wire

@@ hdl/hpe_front.sv @@
`default_nettype none
module hpe_front (
   input  wire               req_push,
   output logic              req_full,
   input  hpe_pkg::req_type  req_data,
   input  hpe_pkg::q_stat_type q_stat,
   output logic              q_wr,
   output hpe_pkg::item_type q_wr_item
);
   import hpe_pkg::*;

   logic [CODE_W-1:0] code;
   logic [LEN_W-1:0]  len;
   logic [LEN_W-1:0]  align;

   assign code  = CODE_ROM[req_data.symbol];
   assign len   = LEN_ROM[req_data.symbol];
   assign align = LEN_W'(CODE_W) - len;

   assign req_full = q_stat.full;
   assign q_wr     = req_push && !q_stat.full;

   always_comb begin
      q_wr_item.code = code << align;
      q_wr_item.len  = len;
      q_wr_item.last = req_data.last_symbol;
   end

endmodule
`default_nettype wire

@@ hdl/hpe_queue.sv @@
`default_nettype none
module hpe_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 wr,
   input  hpe_pkg::item_type   wr_item,
   input  wire                 rd,
   output hpe_pkg::item_type   rd_item,
   output hpe_pkg::q_stat_type stat
);
   import hpe_pkg::*;

   localparam int PTR_W = $clog2(Q_DEPTH);

   item_type             mem_ff [Q_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]       cnt_ff, cnt_in;

   assign stat.full  = cnt_ff == (PTR_W+1)'(Q_DEPTH);
   assign stat.empty = cnt_ff == '0;
   assign rd_item    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr && !rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (rd && !wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule
`default_nettype wire

@@ hdl/hpe_back.sv @@
`default_nettype none
module hpe_back (
   input  wire                 clock,
   input  wire                 reset,
   input  hpe_pkg::q_stat_type q_stat,
   input  hpe_pkg::item_type   q_rd_item,
   output logic                q_rd,
   output logic                rsp_empty,
   input  wire                 rsp_pop,
   output hpe_pkg::rsp_type    rsp_data
);
   import hpe_pkg::*;

   // bits are left-aligned; everything below cnt_ff is zero
   logic [ACC_W-1:0] bits_ff, bits_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             last_ff, last_in;
   logic             out_vld_ff, out_vld_in;
   rsp_type          out_ff, out_in;

   logic             can_out;
   logic             have_byte;
   logic             pad;
   logic             emit;
   logic             load;
   logic [ACC_W-1:0] incoming;

   assign can_out   = !out_vld_ff || rsp_pop;
   assign have_byte = cnt_ff >= CNT_W'(8);
   assign pad       = !have_byte && last_ff && (cnt_ff != '0);
   assign emit      = (have_byte || pad) && can_out;
   assign load      = !have_byte && !pad && !q_stat.empty;
   assign q_rd      = load;
   assign incoming  = {q_rd_item.code, 7'b0} >> cnt_ff[2:0];

   assign rsp_empty = !out_vld_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      bits_in    = bits_ff;
      cnt_in     = cnt_ff;
      last_in    = last_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff && !rsp_pop;
      if (emit) begin
         out_vld_in = 1'b1;
         if (have_byte) begin
            out_in.out_byte  = bits_ff[ACC_W-1 -: 8];
            out_in.last_byte = last_ff && (cnt_ff == CNT_W'(8));
            bits_in          = bits_ff << 8;
            cnt_in           = cnt_ff - CNT_W'(8);
         end else begin
            // EOS prefix fill
            out_in.out_byte  = bits_ff[ACC_W-1 -: 8] | (8'hff >> cnt_ff[2:0]);
            out_in.last_byte = 1'b1;
            bits_in          = '0;
            cnt_in           = '0;
            last_in          = 1'b0;
         end
      end else if (load) begin
         bits_in = bits_ff | incoming;
         cnt_in  = cnt_ff + CNT_W'(q_rd_item.len);
         last_in = q_rd_item.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff    <= '0;
         cnt_ff     <= '0;
         last_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         bits_ff    <= bits_in;
         cnt_ff     <= cnt_in;
         last_ff    <= last_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule
`default_nettype wire

@@ hdl/hpack_huffman_encoder_unit.sv @@
// HPACK Huffman string encoder.
// Input queue port: one string byte per beat on req_data (symbol, last_symbol);
// a beat is taken when req_push is high and req_full is low. last_symbol marks
// the final byte of a string.
// Result queue port: one coded octet per beat on rsp_data (out_byte, last_byte),
// valid while rsp_empty is low, taken when rsp_pop is high. last_byte marks the
// final octet of a string; a trailing partial octet is filled with ones.
// A front stage looks up the code and its length, left-aligns it and writes it
// into a two-entry queue. The back stage merges one queued code into its bit
// buffer once fewer than eight bits are left there, then sends one octet per
// cycle while the receiver takes them, plus a filled final octet; the
// byte-wide result port thus sets the pace. An input beat passes through
// the queue, the bit buffer and the result register on the way to its first octet.
// Reset empties the queue, the bit buffer and the result register.
// When the receiver stalls, the result register holds and the back stage stops
// once it holds a full octet; req_full rises when both queue entries are taken.
`default_nettype none
module hpack_huffman_encoder_unit (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_push,
   output logic             req_full,
   input  hpe_pkg::req_type req_data,
   output logic             rsp_empty,
   input  wire              rsp_pop,
   output hpe_pkg::rsp_type rsp_data
);
   import hpe_pkg::*;

   q_stat_type q_stat;
   logic       q_wr;
   logic       q_rd;
   item_type   q_wr_item;
   item_type   q_rd_item;

   hpe_front u_front (
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .q_wr      (q_wr),
      .q_wr_item (q_wr_item)
   );

   hpe_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr      (q_wr),
      .wr_item (q_wr_item),
      .rd      (q_rd),
      .rd_item (q_rd_item),
      .stat    (q_stat)
   );

   hpe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_rd_item (q_rd_item),
      .q_rd      (q_rd),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result port not empty after reset");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !q_wr)
      else $error("write into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_stat.empty |-> !q_rd)
      else $error("read from empty queue");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting beat changed");

endmodule
`default_nettype wire
